// File: design/crcdf_pkg.sv
package crcdf_pkg;

  // byte position within one three-byte group
  localparam logic [1:0] POS_HIGH = 2'd0;
  localparam logic [1:0] POS_LOW  = 2'd1;
  localparam logic [1:0] POS_CRC  = 2'd2;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [4:0] FRAME_WORDS_RESET = 5'd9;

  typedef struct packed {
    logic [15:0] word_value;
    logic [3:0]  word_index;
    logic        crc_ok;
    logic        last_word;
  } word_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] pos;
  } framer_status_t;

  // crc-8, msb first, one byte folded in
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // index of the last word; zero acts as one word, above sixteen as sixteen
  function automatic logic [3:0] last_index(input logic [4:0] fw);
    logic [3:0] idx;
    if (fw == 5'd0) begin
      idx = 4'd0;
    end else if (fw[4]) begin
      idx = 4'd15;
    end else begin
      idx = fw[3:0] - 4'd1;
    end
    return idx;
  endfunction

endpackage

// File: design/crcdf_rx_if.sv
interface crcdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// File: design/crcdf_word_if.sv
interface crcdf_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_value;
  logic [3:0]  word_index;
  logic        crc_ok;
  logic        last_word;

  modport source (output valid, output word_value, output word_index, output crc_ok,
                  output last_word, input ready);
  modport sink (input valid, input word_value, input word_index, input crc_ok,
                input last_word, output ready);
endinterface

// File: design/crcdf_framer.sv
module crcdf_framer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               rx_byte,
  input  logic                     frame_start,
  input  logic [3:0]               last_idx,
  output crcdf_pkg::word_t         result,
  output crcdf_pkg::framer_status_t status
);

  logic [1:0] pos;
  logic [7:0] high_byte;
  logic [7:0] low_byte;
  logic [7:0] crc;
  logic [3:0] word_counter;

  logic [1:0] pos_eff;
  logic [3:0] idx_eff;
  logic       last;

  always_comb begin
    if (frame_start) begin
      pos_eff = crcdf_pkg::POS_HIGH;
    end else begin
      case (pos)
        crcdf_pkg::POS_LOW: pos_eff = crcdf_pkg::POS_LOW;
        crcdf_pkg::POS_CRC: pos_eff = crcdf_pkg::POS_CRC;
        default:            pos_eff = crcdf_pkg::POS_HIGH;
      endcase
    end
  end

  assign idx_eff = frame_start ? 4'd0 : word_counter;
  assign last    = (idx_eff == last_idx);

  assign result.word_value = {high_byte, low_byte};
  assign result.word_index = idx_eff;
  assign result.crc_ok     = (crc == rx_byte);
  assign result.last_word  = last;

  assign status.emit = (pos_eff == crcdf_pkg::POS_CRC);
  assign status.pos  = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= crcdf_pkg::POS_HIGH;
      crc          <= crcdf_pkg::CRC_INIT;
      word_counter <= 4'd0;
    end else if (take) begin
      case (pos_eff)
        crcdf_pkg::POS_LOW: begin
          crc <= crcdf_pkg::crc8_feed(crc, rx_byte);
          pos <= crcdf_pkg::POS_CRC;
          if (frame_start) begin
            word_counter <= 4'd0;
          end
        end
        crcdf_pkg::POS_CRC: begin
          crc          <= crcdf_pkg::CRC_INIT;
          pos          <= crcdf_pkg::POS_HIGH;
          word_counter <= last ? 4'd0 : idx_eff + 4'd1;
        end
        default: begin
          crc <= crcdf_pkg::crc8_feed(crcdf_pkg::CRC_INIT, rx_byte);
          pos <= crcdf_pkg::POS_LOW;
          if (frame_start) begin
            word_counter <= 4'd0;
          end
        end
      endcase
    end
  end

  // data bytes are always written before a crc beat reads them
  always_ff @(posedge clk) begin
    if (take) begin
      if (pos_eff == crcdf_pkg::POS_HIGH) begin
        high_byte <= rx_byte;
      end
      if (pos_eff == crcdf_pkg::POS_LOW) begin
        low_byte <= rx_byte;
      end
    end
  end

endmodule

// File: design/crc_checked_word_deframer.sv
// a word leaves through the input register and then the result register after its crc beat is accepted
// throughput: one byte beat per cycle while no crc beat waits on a full result slot; one word per three
// beats; the crc-8 byte update is combinational logic between the input register and the framer state
// reset: synchronous, active high; clears byte position, word count, crc to 0xff,
// frame length to nine words, and empties both registers
module crc_checked_word_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [4:0]         cfg_data,
  crcdf_rx_if.sink           rx,
  crcdf_word_if.source       word
);

  // frame length kept as the index of the last word, clamped on write
  logic [3:0] last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx <= crcdf_pkg::last_index(crcdf_pkg::FRAME_WORDS_RESET);
    end else if (cfg_write) begin
      last_idx <= crcdf_pkg::last_index(cfg_data);
    end
  end

  // input register: one byte beat waiting for the framer
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  // result register
  logic              out_valid;
  crcdf_pkg::word_t  out_word;

  crcdf_pkg::word_t          fr_result;
  crcdf_pkg::framer_status_t fr_status;

  logic slot_free;
  logic s1_advance;
  logic out_load;

  // result slot can take a word if empty or draining this cycle
  assign slot_free  = !out_valid || word.ready;
  // data beats never need the slot; crc beats wait for it
  assign s1_advance = s1_valid && (!fr_status.emit || slot_free);
  assign out_load   = s1_advance && fr_status.emit;
  assign rx.ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte  <= rx.rx_byte;
      s1_start <= rx.frame_start;
    end
  end

  crcdf_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .take        (s1_advance),
    .rx_byte     (s1_byte),
    .frame_start (s1_start),
    .last_idx    (last_idx),
    .result      (fr_result),
    .status      (fr_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (word.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= fr_result;
    end
  end

  assign word.valid      = out_valid;
  assign word.word_value = out_word.word_value;
  assign word.word_index = out_word.word_index;
  assign word.crc_ok     = out_word.crc_ok;
  assign word.last_word  = out_word.last_word;

  // last-word flag agrees with the frame length in force
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    word.valid |-> (word.last_word == (word.word_index == last_idx)))
    else $error("last_word does not match word_index");

  // after a word is loaded into the result register the framer expects a high byte
  a_group_restart: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (fr_status.pos == crcdf_pkg::POS_HIGH))
    else $error("byte position not reset after word");

  // a stuck input register must hold off new beats
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> !rx.ready)
    else $error("input beat accepted over a held beat");

  // a word is only loaded into a free or draining slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !word.ready) |-> !out_load)
    else $error("result overwritten before taken");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crcdf_pkg::*;

  // one pending byte beat for the rx side
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_beat_t;

  localparam int STALL_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES  = 4;     // margin for the block to drain
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [4:0] cfg_data = 5'd0;

  // sender and receiver registers, tied onto the interfaces below
  logic tx_valid = 1'b0;
  logic [7:0] tx_byte = 8'd0;
  logic tx_start = 1'b0;
  logic rcv_ready = 1'b0;

  crcdf_rx_if rx_bus ();
  crcdf_word_if word_bus ();

  assign rx_bus.valid = tx_valid;
  assign rx_bus.rx_byte = tx_byte;
  assign rx_bus.frame_start = tx_start;
  assign word_bus.ready = rcv_ready;

  crc_checked_word_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .rx        (rx_bus),
    .word      (word_bus)
  );

  initial forever #6 clk = ~clk;

  // stimulus and expected words
  rx_beat_t byte_q[$];
  word_t    words_due[$];

  int pushed_beats = 0;
  int accepted_beats = 0;
  int words_checked = 0;
  int bad_crc_words = 0;
  int last_flags = 0;
  int settings_used = 0;
  int errors = 0;

  // random idling is switched off while quiet is set
  logic quiet = 1'b0;

  // long stall requests: the initial block bumps stall_req, the receiver acks
  int stall_req = 0;
  int stall_ack = 0;
  int stall_left = 0;

  int idle_run = 0;

  // predictor state, mirrors the block's framer
  logic [4:0] frame_words_cfg = FRAME_WORDS_RESET;
  logic [1:0] grp_pos = POS_HIGH;
  logic [7:0] hi_q = 8'd0;
  logic [7:0] lo_q = 8'd0;
  logic [7:0] crc_acc = CRC_INIT;
  logic [3:0] word_cnt = 4'd0;

  // crc-8 poly 0x31, one input bit at a time, msb first
  function automatic logic [7:0] crc8_poly31(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ 8'h31;
      end
    end
    return r;
  endfunction

  // zero behaves as a one-word frame, anything past sixteen as sixteen
  function automatic int words_per_frame(input logic [4:0] fw);
    if (fw == 5'd0) begin
      return 1;
    end
    if (fw > 5'd16) begin
      return 16;
    end
    return int'(fw);
  endfunction

  // advance the predicted framer by one accepted beat
  function automatic void absorb_byte(input logic [7:0] b, input logic start);
    word_t w;
    logic  is_last;
    if (start) begin
      grp_pos = POS_HIGH;
      word_cnt = 4'd0;
      crc_acc = CRC_INIT;
    end
    case (grp_pos)
      POS_LOW: begin
        lo_q = b;
        crc_acc = crc8_poly31(crc_acc, b);
        grp_pos = POS_CRC;
      end
      POS_CRC: begin
        is_last = (int'(word_cnt) == words_per_frame(frame_words_cfg) - 1);
        w.word_value = {hi_q, lo_q};
        w.word_index = word_cnt;
        w.crc_ok = (crc_acc == b);
        w.last_word = is_last;
        words_due.push_back(w);
        word_cnt = is_last ? 4'd0 : word_cnt + 4'd1;
        grp_pos = POS_HIGH;
        crc_acc = CRC_INIT;
      end
      default: begin
        // position three cannot occur; it folds into the high byte case
        hi_q = b;
        crc_acc = crc8_poly31(CRC_INIT, b);
        grp_pos = POS_LOW;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endtask

  // sender: pops the next beat once the current one is taken
  always @(posedge clk) begin
    rx_beat_t nxt;
    if (rst) begin
      tx_valid <= 1'b0;
    end else begin
      if (tx_valid && rx_bus.ready) begin
        absorb_byte(tx_byte, tx_start);
        accepted_beats++;
      end
      if (!tx_valid || rx_bus.ready) begin
        if (byte_q.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
          nxt = byte_q.pop_front();
          tx_valid <= 1'b1;
          tx_byte <= nxt.data;
          tx_start <= nxt.start;
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each word beat against the oldest prediction
  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      rcv_ready <= 1'b0;
    end else begin
      if (word_bus.valid && rcv_ready) begin
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", word_bus.word_value));
        end else begin
          want = words_due.pop_front();
          words_checked++;
          if (!want.crc_ok) bad_crc_words++;
          if (want.last_word) last_flags++;
          if (word_bus.word_value !== want.word_value)
            report_mismatch($sformatf("word_value %h, want %h",
                                      word_bus.word_value, want.word_value));
          if (word_bus.word_index !== want.word_index)
            report_mismatch($sformatf("word_index %0d, want %0d",
                                      word_bus.word_index, want.word_index));
          if (word_bus.crc_ok !== want.crc_ok)
            report_mismatch($sformatf("crc_ok %b, want %b (word %h)",
                                      word_bus.crc_ok, want.crc_ok, want.word_value));
          if (word_bus.last_word !== want.last_word)
            report_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                      word_bus.last_word, want.last_word, want.word_index));
        end
      end
      if (stall_req != stall_ack) begin
        stall_ack <= stall_req;
        stall_left <= STALL_CYCLES;
        rcv_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= quiet || ($urandom_range(99) >= 16);
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((tx_valid && rx_bus.ready) || (word_bus.valid && rcv_ready)) begin
        idle_run <= 0;
      end else if (idle_run >= QUIET_LIMIT) begin
        $display("tb_top: no handshake for %0d cycles", idle_run);
        $display("tb_top: done, errors");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_beat(input logic [7:0] b, input logic s);
    rx_beat_t e;
    e.data = b;
    e.start = s;
    byte_q.push_back(e);
    pushed_beats++;
  endtask

  // one three-beat group; a bad crc gets a nonzero error pattern
  task automatic queue_word(input logic [15:0] w, input logic s, input logic good);
    logic [7:0] c;
    c = crc8_poly31(crc8_poly31(CRC_INIT, w[15:8]), w[7:0]);
    if (!good) begin
      c = c ^ 8'($urandom_range(1, 255));
    end
    queue_beat(w[15:8], s);
    queue_beat(w[7:0], 1'b0);
    queue_beat(c, 1'b0);
  endtask

  // bias toward the all-zero and all-one bytes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // mostly whole frames, some cut-off groups, some raw noise
  task automatic queue_random(input int n);
    int stop;
    int r;
    int cnt;
    stop = pushed_beats + n;
    while (pushed_beats < stop) begin
      r = $urandom_range(99);
      if (r < 70) begin
        cnt = words_per_frame(frame_words_cfg);
        if ($urandom_range(9) == 0) cnt = $urandom_range(1, 16);
        for (int k = 0; k < cnt; k++) begin
          queue_word({pick_byte(), pick_byte()},
                     (k == 0) && ($urandom_range(9) != 0),
                     $urandom_range(99) >= 15);
        end
      end else if (r < 85) begin
        // partial group, the next frame start has to resync it
        cnt = $urandom_range(1, 2);
        for (int k = 0; k < cnt; k++) begin
          queue_beat(pick_byte(), (k == 0) && ($urandom_range(1) == 1));
        end
      end else begin
        cnt = $urandom_range(1, 6);
        for (int k = 0; k < cnt; k++) begin
          queue_beat(pick_byte(), $urandom_range(99) < 15);
        end
      end
    end
  endtask

  // waits until every queued beat is in and every word is out,
  // then lets the pipeline run dry
  task automatic settle();
    while (accepted_beats != pushed_beats || words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_words(input logic [4:0] fw);
    settle();
    cfg_data <= fw;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_words_cfg = fw;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [4:0] fw;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset frame length of nine
    queue_word(16'h0000, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b0, 1'b1);
    queue_word(16'hBEEF, 1'b0, 1'b0);
    queue_word(16'h8001, 1'b0, 1'b0);
    // frame start on the low byte: that byte becomes the new high byte
    queue_beat(8'h12, 1'b1);
    queue_beat(8'h34, 1'b1);
    queue_beat(8'h56, 1'b0);
    queue_beat(crc8_poly31(crc8_poly31(CRC_INIT, 8'h34), 8'h56), 1'b0);
    // frame start on the crc byte
    queue_beat(8'hAA, 1'b1);
    queue_beat(8'h55, 1'b0);
    queue_beat(8'hC3, 1'b1);
    queue_beat(8'h3C, 1'b0);
    queue_beat(crc8_poly31(crc8_poly31(CRC_INIT, 8'hC3), 8'h3C), 1'b0);
    // a plain continuation word
    queue_word(16'h1234, 1'b0, 1'b1);

    queue_random(100);

    // one-word frames: every word is the last
    write_frame_words(5'd1);
    queue_random(100);

    // widest legal frame with both sides running flat out
    write_frame_words(5'd16);
    quiet = 1'b1;
    queue_random(120);
    settle();
    quiet = 1'b0;

    // zero acts as one
    write_frame_words(5'd0);
    queue_random(80);

    // all-ones register value, clamped to sixteen; receiver holds off so
    // the block backs up onto the byte side
    write_frame_words(5'd31);
    stall_req <= stall_req + 1;
    queue_random(100);

    write_frame_words(5'd17);
    queue_random(80);

    // shrink the frame mid-way: the word count is already past the new
    // last index, so it runs to fifteen and wraps before flagging
    write_frame_words(5'd5);
    queue_word({pick_byte(), pick_byte()}, 1'b1, 1'b1);
    for (int k = 1; k < 4; k++) queue_word({pick_byte(), pick_byte()}, 1'b0, 1'b1);
    write_frame_words(5'd2);
    for (int k = 0; k < 14; k++) queue_word({pick_byte(), pick_byte()}, 1'b0, 1'b1);

    // random lengths, small ones favored
    repeat (4) begin
      fw = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 4));
      write_frame_words(fw);
      queue_random(80);
    end

    settle();
    repeat (10) @(posedge clk);

    $display("tb_top: %0d byte beats, %0d words checked, %0d with crc errors, %0d frame ends",
             accepted_beats, words_checked, bad_crc_words, last_flags);
    $display("tb_top: %0d frame-length writes incl. 0, 1, 16, 17, 31 and a mid-frame shrink",
             settings_used);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/crcdf_pkg.sv
design/crcdf_rx_if.sv
design/crcdf_word_if.sv
design/crcdf_framer.sv
design/crc_checked_word_deframer.sv
verif/tb_top.sv
